/* rtl/efr_pkg.sv */
// Shared types and constants of the escaped byte frame receiver.
`timescale 1ns / 1ps

package efr_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int IDX_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] START_RST  = 8'h50;
  localparam logic [7:0] ESCAPE_RST = 8'h7D;
  localparam logic [7:0] END_RST    = 8'h04;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_ESCAPE = 2'd1;
  localparam logic [1:0] REG_END    = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_INMSG  = 2'd1,
    MODE_AFTESC = 2'd2
  } rx_mode_t;

  typedef enum logic {
    ST_RUN  = 1'b0,
    ST_DUMP = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] escape_byte;
    logic [7:0] end_byte;
  } cfg_t;

  typedef struct packed {
    logic take_in;   // accept input beat, load echo
    logic emit_buf;  // load next buffer byte into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic close;     // current input byte closes the frame
    logic dump_end;  // buffer byte counter at last entry
  } dp_sts_t;

endpackage

/* rtl/efr_cfg.sv */
// Configuration register bank with APB-style access.
`timescale 1ns / 1ps

module efr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [efr_pkg::PADDR_W-1:0]  paddr,
  input  logic [efr_pkg::PDATA_W-1:0]  pwdata,
  output logic [efr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output efr_pkg::cfg_t                cfg_o
);

  efr_pkg::cfg_t cfg_r;
  efr_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    unique case (paddr[3:2])
      efr_pkg::REG_START: begin
        prdata = efr_pkg::PDATA_W'(cfg_r.start_byte);
        if (wr_en) cfg_nxt.start_byte = pwdata[7:0];
      end
      efr_pkg::REG_ESCAPE: begin
        prdata = efr_pkg::PDATA_W'(cfg_r.escape_byte);
        if (wr_en) cfg_nxt.escape_byte = pwdata[7:0];
      end
      efr_pkg::REG_END: begin
        prdata = efr_pkg::PDATA_W'(cfg_r.end_byte);
        if (wr_en) cfg_nxt.end_byte = pwdata[7:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= efr_pkg::START_RST;
      cfg_r.escape_byte <= efr_pkg::ESCAPE_RST;
      cfg_r.end_byte    <= efr_pkg::END_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* rtl/efr_dp.sv */
// Datapath: receive mode, frame buffer, fill count, dump counter, output register.
`timescale 1ns / 1ps

module efr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  efr_pkg::cfg_t      cfg_i,
  input  efr_pkg::dp_cmd_t   cmd_i,
  output efr_pkg::dp_sts_t   sts_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_kind_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic               out_overflow_o
);

  efr_pkg::rx_mode_t                mode_r, mode_nxt;
  logic [efr_pkg::IDX_W-1:0]        fill_r, fill_nxt;
  logic [efr_pkg::ADDR_W-1:0]       cnt_r, cnt_nxt;
  logic [7:0]                       store_r [efr_pkg::FRAME_BYTES];

  logic                             store_req;
  logic                             close;
  logic [efr_pkg::IDX_W-1:0]        base_idx;
  logic                             full;
  logic                             wr_en;
  logic                             dropped;
  logic                             dump_end;

  logic                             kind_r, last_r, ovf_r;
  logic [7:0]                       byte_r;

  // Decode the incoming byte against the current mode.
  always_comb begin
    mode_nxt  = mode_r;
    store_req = 1'b0;
    close     = 1'b0;
    base_idx  = fill_r;
    unique case (mode_r)
      efr_pkg::MODE_INMSG: begin
        if (rx_byte_i == cfg_i.escape_byte) begin
          mode_nxt = efr_pkg::MODE_AFTESC;
        end else if (rx_byte_i == cfg_i.end_byte) begin
          mode_nxt = efr_pkg::MODE_IDLE;
          close    = 1'b1;
        end else begin
          store_req = 1'b1;
        end
      end
      efr_pkg::MODE_AFTESC: begin
        mode_nxt  = efr_pkg::MODE_INMSG;
        store_req = 1'b1;
      end
      default: begin
        // idle and the unused code: only a start byte opens a frame
        mode_nxt = efr_pkg::MODE_IDLE;
        base_idx = '0;
        if (rx_byte_i == cfg_i.start_byte) begin
          mode_nxt  = efr_pkg::MODE_INMSG;
          store_req = 1'b1;
        end
      end
    endcase
  end

  assign full     = base_idx >= efr_pkg::IDX_W'(efr_pkg::FRAME_BYTES);
  assign wr_en    = cmd_i.take_in && store_req && !full;
  assign dropped  = store_req && full;
  assign dump_end = cnt_r == efr_pkg::ADDR_W'(efr_pkg::FRAME_BYTES - 1);

  always_comb begin
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    if (cmd_i.take_in) begin
      fill_nxt = wr_en ? base_idx + 1'b1 : base_idx;
    end else if (cmd_i.emit_buf) begin
      cnt_nxt = cnt_r + 1'b1;
      if (dump_end) begin
        cnt_nxt  = '0;
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= efr_pkg::MODE_IDLE;
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd_i.take_in) mode_r <= mode_nxt;
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_r[base_idx[efr_pkg::ADDR_W-1:0]] <= rx_byte_i;
  end

  // entries at or beyond the fill count are masked on read, so read as zero
  always_ff @(posedge clk) begin
    if (cmd_i.take_in) begin
      kind_r <= 1'b0;
      byte_r <= rx_byte_i;
      last_r <= !close;
      ovf_r  <= dropped;
    end else if (cmd_i.emit_buf) begin
      kind_r <= 1'b1;
      byte_r <= (efr_pkg::IDX_W'(cnt_r) < fill_r) ? store_r[cnt_r] : 8'h00;
      last_r <= dump_end;
      ovf_r  <= 1'b0;
    end
  end

  assign sts_o.close    = close;
  assign sts_o.dump_end = dump_end;

  assign out_kind_o     = kind_r;
  assign out_byte_o     = byte_r;
  assign out_last_o     = last_r;
  assign out_overflow_o = ovf_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= efr_pkg::IDX_W'(efr_pkg::FRAME_BYTES))
    else $error("fill count beyond buffer size");

  a_dump_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit_buf && dump_end |=> fill_r == '0 && cnt_r == '0)
    else $error("buffer not cleared after dump");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.take_in && mode_r == efr_pkg::MODE_IDLE |-> fill_r == '0)
    else $error("stale fill count while idle");
`endif

endmodule

/* rtl/efr_ctrl.sv */
// Controller: accepts beats, sequences the buffer dump, owns output valid.
`timescale 1ns / 1ps

module efr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  efr_pkg::dp_sts_t   sts_i,
  output efr_pkg::dp_cmd_t   cmd_o
);

  efr_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_o         = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      efr_pkg::ST_RUN: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd_o.take_in = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts_i.close) state_nxt = efr_pkg::ST_DUMP;
        end
      end
      efr_pkg::ST_DUMP: begin
        if (out_free) begin
          cmd_o.emit_buf = 1'b1;
          out_valid_nxt  = 1'b1;
          if (sts_i.dump_end) state_nxt = efr_pkg::ST_RUN;
        end
      end
      default: state_nxt = efr_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= efr_pkg::ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_close_dumps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.take_in && sts_i.close |=> state_r == efr_pkg::ST_DUMP)
    else $error("closing byte did not start a dump");

  a_dump_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == efr_pkg::ST_DUMP |-> out_valid_r)
    else $error("output register empty during dump");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.take_in || cmd_o.emit_buf |-> out_free && !(cmd_o.take_in && cmd_o.emit_buf))
    else $error("output register overwritten");
`endif

endmodule

/* rtl/escaped_byte_frame_receiver_top.sv */
// Top level of the escaped byte frame receiver.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------------------
//  in_      | input     | in_valid / in_ready   | in_rx_byte[7:0]
//  out_     | output    | out_valid / out_ready | out_kind, out_byte[7:0], out_last,
//           |           |                       | out_overflow
//  cfg      | input     | psel, penable, pwrite | paddr[3:0], pwdata[31:0] -> prdata
//
//  A byte that does not close a frame is accepted as soon as the single output
//  register is free, and its echo appears the next cycle.
//  A closing byte costs 17 output beats: the echo, then the 16 buffered bytes,
//  one per cycle from the output register while the sink takes them; input is held off meanwhile.
//  A new beat is taken in the same cycle the last result leaves the register.
//  Reset (rst_n low, synchronous) sets the registers to 0x50/0x7D/0x04, mode
//  to idle and the fill count to zero; unfilled buffer entries read as zero.
//  Output stalls simply hold the register and back-pressure the input.
//
//  Registers at byte addresses 0x0 start_byte, 0x4 escape_byte, 0x8 end_byte;
//  writes land in the access phase, pready is tied high.

module escaped_byte_frame_receiver_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input byte channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_rx_byte,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  output logic                         out_overflow,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [efr_pkg::PADDR_W-1:0]  paddr,
  input  logic [efr_pkg::PDATA_W-1:0]  pwdata,
  output logic [efr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  efr_pkg::cfg_t    cfg;
  efr_pkg::dp_cmd_t cmd;
  efr_pkg::dp_sts_t sts;

  // register bank
  efr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshakes and dump sequencing
  efr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // deframing state, frame buffer and output payload
  efr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rx_byte_i      (in_rx_byte),
    .out_kind_o     (out_kind),
    .out_byte_o     (out_byte),
    .out_last_o     (out_last),
    .out_overflow_o (out_overflow)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the escaped byte frame receiver top level.
module tb;

  // Timing and run-length knobs
  localparam int CLK_HALF     = 2;       // 4 ns period
  localparam int RESET_CYCLES = 7;
  localparam int MAX_GAP      = 13;      // per-beat idle draw on either side
  localparam int HOLD_AT_BEAT = 150;     // result beat at which the sink holds off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;      // quiet tail after the last result
  localparam int CYCLE_LIMIT  = 600000;
  localparam int NUM_PHASES   = 6;       // random phases, one register setting each
  localparam int PHASE_ITEMS  = 60;      // roughly this many bytes per phase
  localparam int REPORT_MAX   = 10;

  // Register index past the end of the list; writes to it must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_BUF  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } rx_result_t;

  // One row of the directed table: byte to send and, where pinned, its echo
  typedef struct packed {
    logic [7:0] rx;
    logic       pinned;
    logic       last;
    logic       ovf;
  } dir_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_rx_byte;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_kind;
  logic [7:0]                    out_byte;
  logic                          out_last;
  logic                          out_overflow;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [efr_pkg::PADDR_W-1:0]   paddr;
  logic [efr_pkg::PDATA_W-1:0]   pwdata;
  logic [efr_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  escaped_byte_frame_receiver_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_overflow (out_overflow),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Deframer shadow state, kept in step with the block on every accepted beat
  efr_pkg::rx_mode_t         mode_q;
  logic [efr_pkg::IDX_W-1:0] fill_q;
  logic [7:0]                frame_q [efr_pkg::FRAME_BYTES];
  logic [7:0]                cfg_start;
  logic [7:0]                cfg_escape;
  logic [7:0]                cfg_end;

  rx_result_t       expected_q [$];   // results owed by the block, oldest first
  logic [7:0]       stim_q [$];       // byte stream of the current phase

  int  mismatches     = 0;
  int  items_sent     = 0;
  int  beats_checked  = 0;
  int  frames_closed  = 0;
  int  dropped_bytes  = 0;
  int  cycle_count    = 0;
  bit  sender_quiet   = 1'b0;
  bit  sink_eager     = 1'b0;

  // Clock
  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results still owed",
               cycle_count, expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("MISMATCH %0s", msg);
  endtask

  // Appends a data byte to the frame; reports a drop when the buffer is full
  task automatic stash_byte(input logic [7:0] b, output logic dropped);
    dropped = 1'b0;
    if (fill_q >= efr_pkg::FRAME_BYTES) begin
      dropped = 1'b1;
    end else begin
      frame_q[fill_q[efr_pkg::ADDR_W-1:0]] = b;
      fill_q = fill_q + 1'b1;
    end
  endtask

  // Advances the shadow deframer by one received byte and queues its results:
  // always the echo, then the whole buffer when the byte closes a frame.
  task automatic deframe_byte(input logic [7:0] b);
    logic dropped;
    logic closing;
    dropped = 1'b0;
    closing = 1'b0;
    case (mode_q)
      efr_pkg::MODE_INMSG: begin
        // escape wins over end when both registers hold the same value
        if (b == cfg_escape) begin
          mode_q = efr_pkg::MODE_AFTESC;
        end else if (b == cfg_end) begin
          mode_q  = efr_pkg::MODE_IDLE;
          closing = 1'b1;
        end else begin
          stash_byte(b, dropped);
        end
      end
      efr_pkg::MODE_AFTESC: begin
        // anything after an escape is literal data, specials included
        mode_q = efr_pkg::MODE_INMSG;
        stash_byte(b, dropped);
      end
      default: begin
        // idle, and any stray mode code, behaves as idle
        mode_q = efr_pkg::MODE_IDLE;
        if (b == cfg_start) begin
          fill_q = '0;
          mode_q = efr_pkg::MODE_INMSG;
          stash_byte(b, dropped);
        end
      end
    endcase

    expected_q.push_back('{KIND_ECHO, b, !closing, dropped});
    if (dropped)
      dropped_bytes++;

    if (closing) begin
      for (int k = 0; k < efr_pkg::FRAME_BYTES; k++)
        expected_q.push_back('{KIND_BUF, frame_q[k],
                               (k == efr_pkg::FRAME_BYTES - 1), 1'b0});
      foreach (frame_q[k])
        frame_q[k] = 8'h00;
      fill_q = '0;
      frames_closed++;
    end
  endtask

  // Offers one beat; called and returns at a falling edge. Valid stays high
  // on return so a back-to-back beat never drops it for a step.
  task automatic send_byte(input logic [7:0] b, input logic pinned,
                           input logic last, input logic ovf);
    int gap;
    int slot;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    slot = expected_q.size();
    deframe_byte(b);
    // hand-typed echo takes precedence on pinned table rows
    if (pinned)
      expected_q[slot] = '{KIND_ECHO, b, last, ovf};
    items_sent++;
    @(negedge clk);
  endtask

  // Two-phase register write; called and returns at a falling edge, with
  // the bus returned to idle after the access phase
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & 32'hFFFF_FF00) | efr_pkg::PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      efr_pkg::REG_START:  cfg_start  = val;
      efr_pkg::REG_ESCAPE: cfg_escape = val;
      efr_pkg::REG_END:    cfg_end    = val;
      default:    ;  // no such register
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_check(input logic [1:0] idx, input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== want)
      flag_mismatch($sformatf("register %0d read back %02h, expected %02h",
                              idx, prdata[7:0], want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Result sink: random stalls per beat, eager stretches, and one long
  // hold-off so the single output register fills and the input stalls.
  initial begin : result_sink
    int         stall;
    rx_result_t got;
    rx_result_t want;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (beats_checked % 48 == 0)
        sink_eager = ($urandom_range(0, 2) == 0);
      stall = sink_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (beats_checked == HOLD_AT_BEAT)
        stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{out_kind, out_byte, out_last, out_overflow};
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf(
          "unexpected result kind=%0d byte=%02h last=%0d ovf=%0d",
          got.kind, got.data, got.last, got.ovf));
      end else begin
        want = expected_q.pop_front();
        if (got.kind !== want.kind || got.data !== want.data ||
            got.last !== want.last || got.ovf !== want.ovf)
          flag_mismatch($sformatf({
            "beat %0d: expected kind=%0d byte=%02h last=%0d ovf=%0d, ",
            "got kind=%0d byte=%02h last=%0d ovf=%0d"},
            beats_checked, want.kind, want.data, want.last, want.ovf,
            got.kind, got.data, got.last, got.ovf));
      end
      beats_checked++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    dir_row_t   dir_rows [17];
    logic [7:0] phase_start;
    logic [7:0] phase_escape;
    logic [7:0] phase_end;
    logic [7:0] d;
    int         n;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;

    // Shadow state after reset
    mode_q     = efr_pkg::MODE_IDLE;
    fill_q     = '0;
    cfg_start  = efr_pkg::START_RST;
    cfg_escape = efr_pkg::ESCAPE_RST;
    cfg_end    = efr_pkg::END_RST;
    foreach (frame_q[k])
      frame_q[k] = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk under the reset register values. Pinned rows carry the
    // echo as it must look; the rest, buffer dumps included, come from the
    // shadow deframer.
    dir_rows = '{
      '{8'h00,               1'b1, 1'b1, 1'b0},  // idle noise, lowest value
      '{8'hFF,               1'b1, 1'b1, 1'b0},  // idle noise, highest value
      '{efr_pkg::END_RST,    1'b1, 1'b1, 1'b0},  // end byte while idle: echo only
      '{efr_pkg::ESCAPE_RST, 1'b1, 1'b1, 1'b0},  // escape while idle: echo only
      '{efr_pkg::START_RST,  1'b0, 1'b0, 1'b0},  // opens the frame, stored
      '{efr_pkg::START_RST,  1'b0, 1'b0, 1'b0},  // start inside a frame is data
      '{efr_pkg::ESCAPE_RST, 1'b0, 1'b0, 1'b0},
      '{efr_pkg::END_RST,    1'b0, 1'b0, 1'b0},  // escaped end is data
      '{efr_pkg::ESCAPE_RST, 1'b0, 1'b0, 1'b0},
      '{efr_pkg::ESCAPE_RST, 1'b0, 1'b0, 1'b0},  // escaped escape is data
      '{efr_pkg::ESCAPE_RST, 1'b0, 1'b0, 1'b0},
      '{efr_pkg::START_RST,  1'b0, 1'b0, 1'b0},  // escaped start is data
      '{8'hFF,               1'b0, 1'b0, 1'b0},
      '{8'h00,               1'b0, 1'b0, 1'b0},
      '{efr_pkg::END_RST,    1'b1, 1'b0, 1'b0},  // closes: echo not last, dump follows
      '{efr_pkg::START_RST,  1'b0, 1'b0, 1'b0},  // empty frame: start byte then zeros
      '{efr_pkg::END_RST,    1'b1, 1'b0, 1'b0}
    };
    foreach (dir_rows[r])
      send_byte(dir_rows[r].rx, dir_rows[r].pinned, dir_rows[r].last, dir_rows[r].ovf);
    in_valid <= 1'b0;

    // Random phases, each under its own register setting. Registers only
    // move once the block has handed over every owed result.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin phase_start = 8'h00; phase_escape = 8'hFF; phase_end = 8'h80; end
        1: begin phase_start = 8'hFF; phase_escape = 8'h00; phase_end = 8'hFF; end
        // all three equal: frames open but can never close
        2: begin phase_start = 8'hA5; phase_escape = 8'hA5; phase_end = 8'hA5; end
        // escape shadows end, so again no frame closes
        3: begin
          phase_start  = efr_pkg::START_RST;
          phase_escape = efr_pkg::END_RST;
          phase_end    = efr_pkg::END_RST;
        end
        4: begin
          phase_start  = 8'($urandom_range(0, 255));
          phase_escape = 8'($urandom_range(0, 255));
          phase_end    = 8'($urandom_range(0, 255));
        end
        default: begin
          phase_start  = efr_pkg::START_RST;
          phase_escape = efr_pkg::ESCAPE_RST;
          phase_end    = efr_pkg::END_RST;
        end
      endcase

      // sender waits for the block to drain completely before reconfiguring
      while (expected_q.size() != 0) @(posedge clk);
      @(negedge clk);
      cfg_write(efr_pkg::REG_START, phase_start);
      cfg_write(efr_pkg::REG_ESCAPE, phase_escape);
      cfg_write(efr_pkg::REG_END, phase_end);
      cfg_write(REG_SPARE, 8'($urandom_range(0, 255)));
      cfg_check(efr_pkg::REG_START, cfg_start);
      cfg_check(efr_pkg::REG_ESCAPE, cfg_escape);
      cfg_check(efr_pkg::REG_END, cfg_end);

      // Mostly well-stuffed frames with random content; some line noise
      // before each, some long enough to overflow, some never terminated.
      stim_q.delete();
      while (stim_q.size() < PHASE_ITEMS) begin
        repeat ($urandom_range(0, 2)) stim_q.push_back(8'($urandom_range(0, 255)));
        stim_q.push_back(cfg_start);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 22)
                                        : $urandom_range(0, 12);
        repeat (n) begin
          d = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 7))
            0:       d = cfg_start;
            1:       d = cfg_escape;
            2:       d = cfg_end;
            default: ;
          endcase
          if (d == cfg_escape || d == cfg_end || $urandom_range(0, 19) == 0)
            stim_q.push_back(cfg_escape);
          stim_q.push_back(d);
        end
        if ($urandom_range(0, 7) != 0)
          stim_q.push_back(cfg_end);
      end

      sender_quiet = (p == 2 || p == 5);
      foreach (stim_q[s])
        send_byte(stim_q[s], 1'b0, 1'b0, 1'b0);
      in_valid <= 1'b0;
    end

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes under %0d register settings, checked %0d result beats",
             items_sent, NUM_PHASES + 1, beats_checked);
    $display("Frames closed %0d, dropped bytes flagged %0d, mismatches %0d",
             frames_closed, dropped_bytes, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/efr_pkg.sv
rtl/efr_cfg.sv
rtl/efr_dp.sv
rtl/efr_ctrl.sv
rtl/escaped_byte_frame_receiver_top.sv
tb/tb.sv
